// File: design/assert_macros.svh
// Assertion helpers used by the cache design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBL_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define BBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define BBL_ASSERT(label, clk, rst_n, cond)
`define BBL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/bblc_pkg.sv
package bblc_pkg;
    localparam int DEF_MAX_ENTRIES  = 64;
    localparam int DEF_PAYLOAD_BITS = 16;
    localparam int KEY_W   = 33;
    localparam int BYTES_W = 40;
    localparam int CMD_W   = 2;
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADMIT  = 2'd2;
endpackage

// File: design/bblc_mem.sv
module bblc_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: design/byte_budget_lru_cache_hot_cold.sv
// Keyed cache table with a byte budget and hot/cold LRU eviction. Every command
// is worked by one scan unit that reads the entry memory one entry per cycle and
// rewrites it in the following cycle. A lookup hit or an insert of a present key
// takes two passes over the table and a lookup miss takes one. An insert of a new
// key that is stored goes through a find pass, a check state, an increment pass
// and a write state; on a foreground insert that must make room, each evicted
// entry adds a selection pass, a pick state, an eviction pass and a new check. An
// admit check or an unused command needs no pass. Every command ends in a done
// state that moves its result to the output register, held while an earlier
// result still waits there, and the block is ready again in the cycle after.
// After reset the block clears every table entry before it takes its first
// transfer. The byte limit may be written at any time the block is idle.
`include "assert_macros.svh"
module byte_budget_lru_cache_hot_cold #(
    parameter int MAX_ENTRIES  = bblc_pkg::DEF_MAX_ENTRIES,
    parameter int PAYLOAD_BITS = bblc_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bblc_pkg::BYTES_W-1:0]      i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // block_index, foreground, entry_bytes, payload_tag, zero fill
    input  logic [bblc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // command, is_lod
    input  logic [bblc_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // hit, accepted, payload_out, evicted_count, used_bytes, entry_count
    output logic [bblc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import bblc_pkg::*;

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int PB   = PAYLOAD_BITS;
    localparam int R_LO = 0;
    localparam int P_LO = IW;
    localparam int H_B  = IW + PB;
    localparam int S_LO = H_B + 1;
    localparam int K_LO = S_LO + BYTES_W;
    localparam int V_B  = K_LO + KEY_W;
    localparam int DW   = V_B + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_FIND   = 4'd2;
    localparam logic [3:0] ST_LUPD   = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_VSCAN  = 4'd5;
    localparam logic [3:0] ST_VPICK  = 4'd6;
    localparam logic [3:0] ST_VEVICT = 4'd7;
    localparam logic [3:0] ST_INC    = 4'd8;
    localparam logic [3:0] ST_WRNEW  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0]         r_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic               r_fg;
    logic [BYTES_W-1:0] r_bytes;
    logic [PB-1:0]      r_tag;
    logic [BYTES_W-1:0] r_limit;
    logic [BYTES_W-1:0] r_used;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_evicted;
    logic               r_hit;
    logic               r_acc;
    logic [PB-1:0]      r_pay;
    logic [IW-1:0]      r_slot;
    logic [IW-1:0]      r_srank;
    logic               r_move;
    logic [IW-1:0]      r_addr;
    logic               r_issue;
    logic               r_pend;
    logic [IW-1:0]      r_pidx;
    logic               r_cf;
    logic [IW-1:0]      r_ci;
    logic [IW-1:0]      r_cr;
    logic [BYTES_W-1:0] r_cs;
    logic               r_hf;
    logic [IW-1:0]      r_hi;
    logic [IW-1:0]      r_hr;
    logic [BYTES_W-1:0] r_hs;
    logic [IW-1:0]      r_vi;
    logic [IW-1:0]      r_vr;
    logic [BYTES_W-1:0] r_vs;
    logic               r_ff;
    logic [IW-1:0]      r_fi;
    logic               r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [DW-1:0]      w_rdata;
    logic               w_rv;
    logic [KEY_W-1:0]   w_rk;
    logic [BYTES_W-1:0] w_rs;
    logic               w_rh;
    logic [PB-1:0]      w_rp;
    logic [IW-1:0]      w_rr;
    logic               w_match;
    logic               w_last;
    logic               w_accept;
    logic               w_scan;
    logic [BYTES_W:0]   w_sum;
    logic               w_need;
    logic [BYTES_W:0]   w_in_sum;
    logic [63:0]        w_tag64;
    logic [63:0]        w_pay64;
    logic               w_out_free;
    logic               w_cmd_ins;
    logic               n_we;
    logic [IW-1:0]      n_waddr;
    logic [DW-1:0]      n_wdata;

    assign w_rv = w_rdata[V_B];
    assign w_rk = w_rdata[K_LO +: KEY_W];
    assign w_rs = w_rdata[S_LO +: BYTES_W];
    assign w_rh = w_rdata[H_B];
    assign w_rp = w_rdata[P_LO +: PB];
    assign w_rr = w_rdata[R_LO +: IW];

    assign w_match  = r_pend && w_rv && (w_rk == r_key);
    assign w_last   = r_pend && (r_pidx == LAST_IDX);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_scan   = (r_state == ST_FIND) || (r_state == ST_LUPD) ||
                      (r_state == ST_VSCAN) || (r_state == ST_VEVICT) ||
                      (r_state == ST_INC);
    assign w_sum    = {1'b0, r_used} + {1'b0, r_bytes};
    assign w_need   = (w_sum > {1'b0, r_limit}) || (r_count >= FULL_CNT);
    assign w_in_sum = {1'b0, r_used} + {1'b0, i_s_axis_tdata[72:33]};
    assign w_tag64  = 64'(i_s_axis_tdata[88:73]);
    assign w_pay64  = 64'(r_pay);
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign w_cmd_ins  = (r_cmd == CMD_INSERT);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_pidx;
        n_wdata = w_rdata;
        unique case (r_state)
            ST_CLEAR: begin
                n_we    = 1'b1;
                n_waddr = r_addr;
                n_wdata = '0;
            end
            ST_LUPD: begin
                n_we = r_pend;
                if (r_pidx == r_slot) begin
                    n_wdata[H_B] = w_rh | r_fg;
                    if (r_move) begin
                        n_wdata[R_LO +: IW] = '0;
                    end
                end else if (r_move && w_rv && (w_rr < r_srank)) begin
                    n_wdata[R_LO +: IW] = w_rr + 1'b1;
                end
            end
            ST_VEVICT: begin
                n_we = r_pend;
                if (r_pidx == r_vi) begin
                    n_wdata[V_B] = 1'b0;
                end else if (w_rv && (w_rr > r_vr)) begin
                    n_wdata[R_LO +: IW] = w_rr - 1'b1;
                end
            end
            ST_INC: begin
                n_we = r_pend && w_rv;
                n_wdata[R_LO +: IW] = w_rr + 1'b1;
            end
            ST_WRNEW: begin
                n_we    = 1'b1;
                n_waddr = r_fi;
                n_wdata = {1'b1, r_key, r_bytes, r_fg, r_tag, {IW{1'b0}}};
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    bblc_mem #(
        .DEPTH (MAX_ENTRIES),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_scan && r_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rdata),
        .i_wr_en   (n_we),
        .i_wr_addr (n_waddr),
        .i_wr_data (n_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_limit   <= '0;
            r_used    <= '0;
            r_count   <= '0;
            r_addr    <= '0;
            r_issue   <= 1'b0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_cf      <= 1'b0;
            r_hf      <= 1'b0;
            r_ff      <= 1'b0;
            r_hit     <= 1'b0;
            r_acc     <= 1'b0;
            r_evicted <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_scan) begin
                r_pend <= r_issue;
                r_pidx <= r_addr;
                if (r_issue) begin
                    if (r_addr == LAST_IDX) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_addr == LAST_IDX) begin
                        r_state <= ST_IDLE;
                        r_addr  <= '0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= i_s_axis_tuser[1:0];
                        r_key     <= {i_s_axis_tuser[2], i_s_axis_tdata[31:0]};
                        r_fg      <= i_s_axis_tdata[32];
                        r_bytes   <= i_s_axis_tdata[72:33];
                        r_tag     <= w_tag64[PB-1:0];
                        r_hit     <= 1'b0;
                        r_acc     <= 1'b0;
                        r_pay     <= '0;
                        r_evicted <= '0;
                        r_addr    <= '0;
                        r_pend    <= 1'b0;
                        priority if ((i_s_axis_tuser[1:0] == CMD_LOOKUP) ||
                                     (i_s_axis_tuser[1:0] == CMD_INSERT)) begin
                            r_issue <= 1'b1;
                            r_state <= ST_FIND;
                        end else if (i_s_axis_tuser[1:0] == CMD_ADMIT) begin
                            r_acc   <= (i_s_axis_tdata[72:33] <= r_limit) &&
                                       (w_in_sum <= {1'b0, r_limit});
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_FIND: begin
                    if (w_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_pidx;
                        r_srank <= w_rr;
                        r_pay   <= w_rp;
                    end
                    if (w_last) begin
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                        r_pend  <= 1'b0;
                        if (r_hit || w_match) begin
                            r_move  <= (r_cmd == CMD_LOOKUP);
                            r_acc   <= (r_cmd == CMD_INSERT);
                            r_state <= ST_LUPD;
                        end else if (r_cmd == CMD_INSERT) begin
                            r_issue <= 1'b0;
                            r_state <= ST_CHECK;
                        end else begin
                            r_issue <= 1'b0;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_LUPD: begin
                    if (w_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_CHECK: begin
                    r_addr <= '0;
                    r_pend <= 1'b0;
                    r_cf   <= 1'b0;
                    r_hf   <= 1'b0;
                    r_ff   <= 1'b0;
                    priority if (r_bytes > r_limit) begin
                        r_state <= ST_DONE;
                    end else if (!w_need) begin
                        r_issue <= 1'b1;
                        r_state <= ST_INC;
                    end else if (!r_fg) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_issue <= 1'b1;
                        r_state <= ST_VSCAN;
                    end
                end
                ST_VSCAN: begin
                    if (r_pend && w_rv) begin
                        if (!w_rh) begin
                            if (!r_cf || (w_rr > r_cr)) begin
                                r_cf <= 1'b1;
                                r_ci <= r_pidx;
                                r_cr <= w_rr;
                                r_cs <= w_rs;
                            end
                        end else if (!r_hf || (w_rr > r_hr)) begin
                            r_hf <= 1'b1;
                            r_hi <= r_pidx;
                            r_hr <= w_rr;
                            r_hs <= w_rs;
                        end
                    end
                    if (w_last) begin
                        r_state <= ST_VPICK;
                    end
                end
                ST_VPICK: begin
                    r_addr <= '0;
                    r_pend <= 1'b0;
                    priority if (r_cf) begin
                        r_vi    <= r_ci;
                        r_vr    <= r_cr;
                        r_vs    <= r_cs;
                        r_issue <= 1'b1;
                        r_state <= ST_VEVICT;
                    end else if (r_hf) begin
                        r_vi    <= r_hi;
                        r_vr    <= r_hr;
                        r_vs    <= r_hs;
                        r_issue <= 1'b1;
                        r_state <= ST_VEVICT;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_VEVICT: begin
                    if (w_last) begin
                        r_used    <= (r_vs < r_used) ? (r_used - r_vs) : '0;
                        r_count   <= r_count - 1'b1;
                        r_evicted <= r_evicted + 1'b1;
                        r_state   <= ST_CHECK;
                    end
                end
                ST_INC: begin
                    if (r_pend && !w_rv && !r_ff) begin
                        r_ff <= 1'b1;
                        r_fi <= r_pidx;
                    end
                    if (w_last) begin
                        r_state <= ST_WRNEW;
                    end
                end
                ST_WRNEW: begin
                    r_used  <= w_sum[BYTES_W-1:0];
                    r_count <= r_count + 1'b1;
                    r_acc   <= 1'b1;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'(r_count), r_used, 7'(r_evicted),
                                     16'(w_pay64), r_acc, r_hit};
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `BBL_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT)
    `BBL_ASSERT_IMP(a_evict_only_ins, i_clk, i_rst_n, (r_state == ST_DONE) && |r_evicted, w_cmd_ins)
    `BBL_ASSERT_IMP(a_new_has_room, i_clk, i_rst_n, r_state == ST_WRNEW, r_ff && (r_count < FULL_CNT))
    `BBL_ASSERT_IMP(a_evict_needs_fg, i_clk, i_rst_n, r_state == ST_VSCAN, r_fg && w_cmd_ins)
endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bblc_pkg::*;

    localparam int NSLOT = DEF_MAX_ENTRIES;
    localparam int EXP_DEPTH = 4;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [39:0] LIMIT_MAX = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic        hit;
        logic        accepted;
        logic [15:0] payload;
        logic [6:0]  evicted;
        logic [39:0] used;
        logic [6:0]  count;
    } t_cache_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [BYTES_W-1:0]    i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    byte_budget_lru_cache_hot_cold u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow copy of the cache table.
    logic [39:0] budget;
    logic [39:0] used_total;
    bit          slot_valid [NSLOT];
    logic [32:0] slot_key   [NSLOT];
    logic [39:0] slot_size  [NSLOT];
    bit          slot_hot   [NSLOT];
    logic [15:0] slot_tag   [NSLOT];
    int          slot_age   [NSLOT];

    t_cache_result exp_q [EXP_DEPTH];
    int  exp_wr;
    int  exp_rd;
    int  failures;
    bit  no_idle;
    bit  hold_go;
    int  hold_left;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) if (slot_valid[i]) n++;
        return n;
    endfunction

    function automatic int find_slot(logic [32:0] key);
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void touch(int s);
        int r;
        r = slot_age[s];
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic bit drop_oldest(bit want_hot);
        int v;
        int r;
        v = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!slot_valid[i] || slot_hot[i] != want_hot) continue;
            if (v < 0 || slot_age[i] > slot_age[v]) v = i;
        end
        if (v < 0) return 0;
        r = slot_age[v];
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
        used_total = (slot_size[v] < used_total) ? used_total - slot_size[v] : '0;
        slot_valid[v] = 0;
        return 1;
    endfunction

    function automatic t_cache_result apply_request(logic [1:0] cmd, logic [32:0] key,
            bit fg, logic [39:0] nbytes, logic [15:0] tag);
        t_cache_result r;
        int s;
        bit ok;
        r = '0;
        if (cmd == CMD_LOOKUP) begin
            s = find_slot(key);
            if (s >= 0) begin
                r.hit = 1;
                touch(s);
                if (fg) slot_hot[s] = 1;
                r.payload = slot_tag[s];
            end
        end else if (cmd == CMD_INSERT) begin
            s = find_slot(key);
            if (s >= 0) begin
                r.hit = 1;
                r.accepted = 1;
                if (fg) slot_hot[s] = 1;
                r.payload = slot_tag[s];
            end else if (nbytes <= budget) begin
                ok = ({1'b0, used_total} + nbytes <= {1'b0, budget}) && live_count() < NSLOT;
                if (!ok && fg) begin
                    ok = 1;
                    while (({1'b0, used_total} + nbytes > {1'b0, budget})
                           || live_count() >= NSLOT) begin
                        if (drop_oldest(0) || drop_oldest(1)) begin
                            r.evicted++;
                        end else begin
                            ok = 0;
                            break;
                        end
                    end
                end
                if (ok) begin
                    s = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (!slot_valid[i] && s < 0) s = i;
                    if (s >= 0) begin
                        for (int i = 0; i < NSLOT; i++) if (slot_valid[i]) slot_age[i]++;
                        slot_valid[s] = 1;
                        slot_key[s] = key;
                        slot_size[s] = nbytes;
                        slot_hot[s] = fg;
                        slot_tag[s] = tag;
                        slot_age[s] = 0;
                        used_total = used_total + nbytes;
                        r.accepted = 1;
                    end
                end
            end
        end else if (cmd == CMD_ADMIT) begin
            r.accepted = (nbytes <= budget) && ({1'b0, used_total} + nbytes <= {1'b0, budget});
        end
        r.used = used_total;
        r.count = 7'(live_count());
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, bit lod, logic [31:0] idx, bit fg,
            logic [39:0] nbytes, logic [15:0] tag);
        while (!no_idle && $urandom_range(99) < 25) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, tag, nbytes, fg, idx};
        i_s_axis_tuser  <= {lod, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        exp_q[exp_wr % EXP_DEPTH] = apply_request(cmd, {lod, idx}, fg, nbytes, tag);
        exp_wr++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_budget(logic [39:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        budget = value;
    endtask

    task automatic send_random(int nitems, int key_span, logic [39:0] size_span);
        int pick;
        logic [31:0] idx;
        logic [39:0] nbytes;
        logic [1:0] cmd;
        for (int n = 0; n < nitems; n++) begin
            pick = $urandom_range(99);
            cmd = (pick < 50) ? CMD_INSERT : (pick < 82) ? CMD_LOOKUP :
                  (pick < 96) ? CMD_ADMIT : CMD_UNUSED;
            idx = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(key_span - 1);
            nbytes = ($urandom_range(19) == 0) ? 40'({$urandom(), $urandom()}) :
                     40'({$urandom(), $urandom()} % (size_span + 1));
            send_item(cmd, $urandom_range(1), idx, $urandom_range(2) != 0, nbytes,
                      16'($urandom()));
        end
    endtask

    task automatic test_directed();
        set_budget('0);
        send_item(CMD_INSERT, 0, 32'd0, 0, 40'd0, 16'h0000);
        send_item(CMD_INSERT, 1, 32'hFFFF_FFFF, 1, 40'd1, 16'hFFFF);
        send_item(CMD_ADMIT, 0, 32'd0, 0, 40'd0, 16'd0);
        send_item(CMD_ADMIT, 1, 32'd0, 1, LIMIT_MAX, 16'd0);
        send_item(CMD_LOOKUP, 0, 32'd0, 1, 40'd0, 16'd0);
        send_item(CMD_LOOKUP, 1, 32'd0, 0, 40'd0, 16'd0);
        send_item(CMD_UNUSED, 1, 32'hFFFF_FFFF, 1, LIMIT_MAX, 16'hFFFF);
        set_budget(40'd1000);
        send_item(CMD_INSERT, 1, 32'hFFFF_FFFF, 0, 40'd600, 16'hFFFF);
        send_item(CMD_INSERT, 0, 32'd7, 0, 40'd600, 16'h1234);
        send_item(CMD_INSERT, 0, 32'd7, 1, 40'd600, 16'h1234);
        send_item(CMD_INSERT, 0, 32'd7, 1, 40'd5, 16'h5555);
        send_item(CMD_LOOKUP, 0, 32'd7, 1, 40'd0, 16'd0);
        send_item(CMD_INSERT, 0, 32'd8, 0, 40'd1001, 16'h0001);
        send_item(CMD_INSERT, 0, 32'd9, 0, 40'd300, 16'h0002);
        send_item(CMD_INSERT, 0, 32'd10, 1, 40'd1000, 16'h0003);
        set_budget(40'd100);
        send_item(CMD_ADMIT, 0, 32'd0, 0, 40'd0, 16'd0);
        send_item(CMD_INSERT, 0, 32'd11, 1, 40'd100, 16'h0004);
        set_budget(LIMIT_MAX);
        send_item(CMD_INSERT, 1, 32'd12, 0, LIMIT_MAX, 16'h0005);
        send_item(CMD_ADMIT, 0, 32'd0, 0, 40'd0, 16'd0);
        send_item(CMD_INSERT, 1, 32'd13, 1, 40'd1, 16'h0006);
    endtask

    task automatic test_small_budget();
        set_budget(40'd2000);
        send_random(220, 40, 40'd300);
    endtask

    task automatic test_full_table();
        set_budget(LIMIT_MAX);
        no_idle = 1;
        send_random(60, 100, 40'd1000);
        no_idle = 0;
        send_random(200, 100, 40'd1000);
    endtask

    task automatic test_wide_sizes();
        set_budget(40'h80_0000_0000);
        send_random(80, 20, LIMIT_MAX);
    endtask

    task automatic test_backpressure();
        set_budget(40'd5000);
        hold_go = 1;
        no_idle = 1;
        send_random(60, 30, 40'd800);
        no_idle = 0;
    endtask

    task automatic test_zero_budget();
        set_budget('0);
        send_random(110, 10, 40'd2);
    endtask

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        t_cache_result got;
        t_cache_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.hit      = o_m_axis_tdata[0];
            got.accepted = o_m_axis_tdata[1];
            got.payload  = o_m_axis_tdata[17:2];
            got.evicted  = o_m_axis_tdata[24:18];
            got.used     = o_m_axis_tdata[64:25];
            got.count    = o_m_axis_tdata[71:65];
            if (exp_wr == exp_rd) begin
                $display("%t unexpected result %h", $time, got);
                failures++;
            end else begin
                want = exp_q[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.hit != want.hit) begin
                    $display("%t hit expected %h actual %h", $time, want.hit, got.hit);
                    failures++;
                end
                if (got.accepted != want.accepted) begin
                    $display("%t accepted expected %h actual %h", $time, want.accepted,
                             got.accepted);
                    failures++;
                end
                if (got.payload != want.payload) begin
                    $display("%t payload expected %h actual %h", $time, want.payload,
                             got.payload);
                    failures++;
                end
                if (got.evicted != want.evicted) begin
                    $display("%t evicted expected %0d actual %0d", $time, want.evicted,
                             got.evicted);
                    failures++;
                end
                if (got.used != want.used) begin
                    $display("%t used expected %0d actual %0d", $time, want.used, got.used);
                    failures++;
                end
                if (got.count != want.count) begin
                    $display("%t count expected %0d actual %0d", $time, want.count,
                             got.count);
                    failures++;
                end
            end
        end
    end

    initial begin
        #2_000_000_000;
        $display("byte_budget_lru_cache_hot_cold: mismatch");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        failures = 0;
        exp_wr = 0;
        exp_rd = 0;
        no_idle = 0;
        hold_go = 0;
        hold_left = 0;
        budget = '0;
        used_total = '0;
        for (int i = 0; i < NSLOT; i++) slot_valid[i] = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_small_budget();
        test_full_table();
        test_wide_sizes();
        test_backpressure();
        test_zero_budget();
        wait_idle();
        if (failures == 0) begin
            $display("byte_budget_lru_cache_hot_cold: match");
        end else begin
            $display("byte_budget_lru_cache_hot_cold: mismatch");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/bblc_pkg.sv
design/bblc_mem.sv
design/byte_budget_lru_cache_hot_cold.sv
sim/tb.sv
